>>> rtl/dvn_pkg.sv
// shared types and constants for the direction vector normalizer
// no dependencies
`timescale 1ns / 1ps

package dvn_pkg;

   localparam int LANES = 3;

   // sideband that travels with every item through the cell chain
   typedef struct packed {
      logic             valid;
      logic [LANES-1:0] neg;
      logic             zero;
      logic             last;
   } side_type;

endpackage

>>> rtl/dvn_chan_if.sv
// valid/ready channel interfaces for ray requests and unit-vector responses
// no dependencies
`timescale 1ns / 1ps

interface dvn_req_if #(parameter int COMP_BITS = 24);
   logic                        valid;
   logic                        ready;
   logic signed [COMP_BITS-1:0] comp_x;
   logic signed [COMP_BITS-1:0] comp_y;
   logic signed [COMP_BITS-1:0] comp_z;
   logic                        last_in;

   modport source(output valid, comp_x, comp_y, comp_z, last_in, input ready);
   modport sink(input valid, comp_x, comp_y, comp_z, last_in, output ready);
endinterface

interface dvn_rsp_if #(parameter int OUT_BITS = 24);
   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] unit_x;
   logic signed [OUT_BITS-1:0] unit_y;
   logic signed [OUT_BITS-1:0] unit_z;
   logic                       zero_vector;
   logic                       last_out;

   modport source(output valid, unit_x, unit_y, unit_z, zero_vector, last_out,
                  input ready);
   modport sink(input valid, unit_x, unit_y, unit_z, zero_vector, last_out,
                output ready);
endinterface

>>> rtl/dvn_div_cell.sv
// one restoring-division cell: produces one quotient bit for all three lanes
// depends on dvn_pkg
`timescale 1ns / 1ps

module dvn_div_cell #(
   parameter int SUM_W = 48,
   parameter int Q_W   = 45,
   parameter bit FIRST = 1'b0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  dvn_pkg::side_type                side_in,
   input  logic [SUM_W-1:0]                 den_in,
   input  logic [dvn_pkg::LANES-1:0][SUM_W-1:0] rem_in,
   input  logic [dvn_pkg::LANES-1:0][Q_W-1:0]   quo_in,
   output dvn_pkg::side_type                side_out,
   output logic [SUM_W-1:0]                 den_out,
   output logic [dvn_pkg::LANES-1:0][SUM_W-1:0] rem_out,
   output logic [dvn_pkg::LANES-1:0][Q_W-1:0]   quo_out
);
   import dvn_pkg::*;

   side_type                   side_ff;
   logic [SUM_W-1:0]           den_ff;
   logic [LANES-1:0][SUM_W-1:0] rem_ff, rem_in_w;
   logic [LANES-1:0][Q_W-1:0]   quo_ff, quo_in_w;

   always_comb begin
      logic [SUM_W:0] t;
      logic           ge;
      for (int k = 0; k < LANES; k++) begin
         t = FIRST ? {1'b0, rem_in[k]} : {rem_in[k], 1'b0};
         ge = t >= {1'b0, den_in};
         rem_in_w[k] = ge ? SUM_W'(t - {1'b0, den_in}) : SUM_W'(t);
         quo_in_w[k] = {quo_in[k][Q_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (en) begin
         side_ff.valid <= side_in.valid;
      end
      if (en) begin
         side_ff.neg  <= side_in.neg;
         side_ff.zero <= side_in.zero;
         side_ff.last <= side_in.last;
         den_ff       <= den_in;
         rem_ff       <= rem_in_w;
         quo_ff       <= quo_in_w;
      end
   end

   assign side_out = side_ff;
   assign den_out  = den_ff;
   assign rem_out  = rem_ff;
   assign quo_out  = quo_ff;

endmodule

>>> rtl/dvn_sqrt_cell.sv
// one integer square-root cell: produces one root bit for all three lanes
// depends on dvn_pkg
`timescale 1ns / 1ps

module dvn_sqrt_cell #(
   parameter int RAD_W = 46,
   parameter int RW    = 23
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  dvn_pkg::side_type                 side_in,
   input  logic [dvn_pkg::LANES-1:0][RAD_W-1:0] rad_in,
   input  logic [dvn_pkg::LANES-1:0][RW+1:0]    rem_in,
   input  logic [dvn_pkg::LANES-1:0][RW-1:0]    root_in,
   output dvn_pkg::side_type                 side_out,
   output logic [dvn_pkg::LANES-1:0][RAD_W-1:0] rad_out,
   output logic [dvn_pkg::LANES-1:0][RW+1:0]    rem_out,
   output logic [dvn_pkg::LANES-1:0][RW-1:0]    root_out
);
   import dvn_pkg::*;

   side_type                    side_ff;
   logic [LANES-1:0][RAD_W-1:0] rad_ff, rad_in_w;
   logic [LANES-1:0][RW+1:0]    rem_ff, rem_in_w;
   logic [LANES-1:0][RW-1:0]    root_ff, root_in_w;

   always_comb begin
      logic [RW+3:0] sh;
      logic [RW+3:0] trial;
      logic          ge;
      for (int k = 0; k < LANES; k++) begin
         sh    = {rem_in[k], rad_in[k][RAD_W-1:RAD_W-2]};
         trial = {2'b00, root_in[k], 2'b01};
         ge    = sh >= trial;
         rem_in_w[k]  = ge ? (RW+2)'(sh - trial) : (RW+2)'(sh);
         root_in_w[k] = {root_in[k][RW-2:0], ge};
         rad_in_w[k]  = {rad_in[k][RAD_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (en) begin
         side_ff.valid <= side_in.valid;
      end
      if (en) begin
         side_ff.neg  <= side_in.neg;
         side_ff.zero <= side_in.zero;
         side_ff.last <= side_in.last;
         rad_ff       <= rad_in_w;
         rem_ff       <= rem_in_w;
         root_ff      <= root_in_w;
      end
   end

   assign side_out = side_ff;
   assign rad_out  = rad_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;

endmodule

>>> rtl/direction_vector_normalize.sv
// throughput: one item per cycle; the whole chain advances together and holds
//   while the response register is full and not taken
// pipeline: the division chain (one cell per quotient bit, 2*FRAC_BITS+1)
//   plus the square-root chain (one cell per root bit, FRAC_BITS+1), plus four
//   registers for magnitude, squares, sum and response
// reset: synchronous, clears all valid bits; data registers are not reset
`timescale 1ns / 1ps

module direction_vector_normalize #(
   parameter int COMP_BITS = 24,
   parameter int FRAC_BITS = 22
) (
   input  logic      clock,
   input  logic      reset,
   dvn_req_if.sink   req_chan,
   dvn_rsp_if.source rsp_chan
);
   import dvn_pkg::*;

   localparam int SUM_W = 2 * COMP_BITS;      // exact sum of three squares
   localparam int Q_W   = 2 * FRAC_BITS + 1;  // quotient up to 2^(2*frac)
   localparam int RAD_W = 2 * FRAC_BITS + 2;  // quotient padded to whole bit pairs
   localparam int RW    = FRAC_BITS + 1;      // root up to 2^frac
   localparam int OUT_W = FRAC_BITS + 2;

   // chain advances when the response register is free or being taken
   logic advance;
   assign advance        = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   // stage a: magnitudes and signs
   side_type                        a_side_ff, a_side_in;
   logic [LANES-1:0][COMP_BITS-1:0] a_mag_ff, a_mag_in;
   logic [LANES-1:0][COMP_BITS-1:0] raw;

   assign raw = {req_chan.comp_z, req_chan.comp_y, req_chan.comp_x};

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         a_side_in.neg[k] = raw[k][COMP_BITS-1];
         a_mag_in[k]      = raw[k][COMP_BITS-1] ? COMP_BITS'(-raw[k]) : raw[k];
      end
      a_side_in.valid = req_chan.valid;
      a_side_in.zero  = (raw == '0);
      a_side_in.last  = req_chan.last_in;
   end

   // stage b: squares
   side_type                    b_side_ff;
   logic [LANES-1:0][SUM_W-1:0] b_sq_ff;

   // stage c: sum and squares
   side_type                    c_side_ff;
   logic [LANES-1:0][SUM_W-1:0] c_sq_ff;
   logic [SUM_W-1:0]            c_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_side_ff.valid <= 1'b0;
         b_side_ff.valid <= 1'b0;
         c_side_ff.valid <= 1'b0;
      end else if (advance) begin
         a_side_ff.valid <= a_side_in.valid;
         b_side_ff.valid <= a_side_ff.valid;
         c_side_ff.valid <= b_side_ff.valid;
      end
      if (advance) begin
         a_side_ff.neg  <= a_side_in.neg;
         a_side_ff.zero <= a_side_in.zero;
         a_side_ff.last <= a_side_in.last;
         a_mag_ff       <= a_mag_in;
         b_side_ff.neg  <= a_side_ff.neg;
         b_side_ff.zero <= a_side_ff.zero;
         b_side_ff.last <= a_side_ff.last;
         for (int k = 0; k < LANES; k++) begin
            b_sq_ff[k] <= SUM_W'(a_mag_ff[k] * a_mag_ff[k]);
         end
         c_side_ff.neg  <= b_side_ff.neg;
         c_side_ff.zero <= b_side_ff.zero;
         c_side_ff.last <= b_side_ff.last;
         c_sq_ff        <= b_sq_ff;
         c_sum_ff       <= b_sq_ff[0] + b_sq_ff[1] + b_sq_ff[2];
      end
   end

   // division chain: floor(sq * 2^(2*frac) / sum), one quotient bit per cell
   side_type                    dv_side [Q_W+1];
   logic [SUM_W-1:0]            dv_den  [Q_W+1];
   logic [LANES-1:0][SUM_W-1:0] dv_rem  [Q_W+1];
   logic [LANES-1:0][Q_W-1:0]   dv_quo  [Q_W+1];

   assign dv_side[0] = c_side_ff;
   assign dv_den[0]  = c_sum_ff;
   assign dv_rem[0]  = c_sq_ff;
   assign dv_quo[0]  = '0;

   for (genvar i = 0; i < Q_W; i++) begin : g_div
      dvn_div_cell #(
         .SUM_W(SUM_W),
         .Q_W  (Q_W),
         .FIRST(i == 0)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (advance),
         .side_in (dv_side[i]),
         .den_in  (dv_den[i]),
         .rem_in  (dv_rem[i]),
         .quo_in  (dv_quo[i]),
         .side_out(dv_side[i+1]),
         .den_out (dv_den[i+1]),
         .rem_out (dv_rem[i+1]),
         .quo_out (dv_quo[i+1])
      );
   end

   // square-root chain: one root bit per cell
   side_type                    sq_side [RW+1];
   logic [LANES-1:0][RAD_W-1:0] sq_rad  [RW+1];
   logic [LANES-1:0][RW+1:0]    sq_rem  [RW+1];
   logic [LANES-1:0][RW-1:0]    sq_root [RW+1];

   assign sq_side[0] = dv_side[Q_W];
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar k = 0; k < LANES; k++) begin : g_rad
      assign sq_rad[0][k] = {1'b0, dv_quo[Q_W][k]};
   end

   for (genvar i = 0; i < RW; i++) begin : g_sqrt
      dvn_sqrt_cell #(
         .RAD_W(RAD_W),
         .RW   (RW)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (advance),
         .side_in (sq_side[i]),
         .rad_in  (sq_rad[i]),
         .rem_in  (sq_rem[i]),
         .root_in (sq_root[i]),
         .side_out(sq_side[i+1]),
         .rad_out (sq_rad[i+1]),
         .rem_out (sq_rem[i+1]),
         .root_out(sq_root[i+1])
      );
   end

   // response register: apply sign, force zeros for a zero vector
   logic                        out_valid_ff;
   logic [LANES-1:0][OUT_W-1:0] out_unit_ff, out_unit_in;
   logic                        out_zero_ff;
   logic                        out_last_ff;

   always_comb begin
      logic [OUT_W-1:0] mag;
      for (int k = 0; k < LANES; k++) begin
         mag = {1'b0, sq_root[RW][k]};
         if (sq_side[RW].zero) begin
            out_unit_in[k] = '0;
         end else begin
            out_unit_in[k] = sq_side[RW].neg[k] ? OUT_W'(-mag) : mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= sq_side[RW].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_unit_ff <= out_unit_in;
         out_zero_ff <= sq_side[RW].zero;
         out_last_ff <= sq_side[RW].last;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.unit_x      = out_unit_ff[0];
   assign rsp_chan.unit_y      = out_unit_ff[1];
   assign rsp_chan.unit_z      = out_unit_ff[2];
   assign rsp_chan.zero_vector = out_zero_ff;
   assign rsp_chan.last_out    = out_last_ff;

endmodule

>>> tb/tb.sv
// testbench for the direction vector normalizer: random and directed rays,
// predicted unit vectors compared against every response item
// depends on dvn_pkg, dvn_chan_if and direction_vector_normalize
`timescale 1ns / 1ps

module tb;
   import dvn_pkg::*;

   localparam int COMP_BITS = 24;
   localparam int FRAC_BITS = 22;
   localparam int OUT_BITS = FRAC_BITS + 2;
   localparam int PIPE_LAT = 3 * FRAC_BITS + 6;

   typedef logic signed [COMP_BITS-1:0] comp_type;
   typedef logic signed [OUT_BITS-1:0] unit_type;

   typedef struct packed {
      unit_type ux;
      unit_type uy;
      unit_type uz;
      logic     zero;
      logic     last;
   } unit_vec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count = 0;
   bit   stall_on = 1'b1;
   int   burst_left = 0;

   unit_vec_type unit_queue[$];

   dvn_req_if #(.COMP_BITS(COMP_BITS)) req_chan ();
   dvn_rsp_if #(.OUT_BITS(OUT_BITS)) rsp_chan ();

   direction_vector_normalize #(
      .COMP_BITS(COMP_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #5 clock = ~clock;

   // exact integer square root, floor
   function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
      logic [63:0] root;
      logic [63:0] rem;
      logic [63:0] bitv;
      root = 0;
      rem = n;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // unit vector of one ray, using wide exact arithmetic
   function automatic unit_vec_type normalize_ray(input comp_type x, input comp_type y,
                                                  input comp_type z, input logic last);
      unit_vec_type r;
      logic [47:0]  sq[3];
      logic [49:0]  sum;
      logic [95:0]  quo;
      logic [63:0]  root;
      logic [23:0]  mag[3];
      logic         neg[3];
      comp_type     c[3];
      unit_type     u[3];
      c[0] = x;
      c[1] = y;
      c[2] = z;
      sum = 0;
      for (int k = 0; k < 3; k++) begin
         neg[k] = c[k][COMP_BITS-1];
         mag[k] = neg[k] ? -c[k] : c[k];
         sq[k] = mag[k] * mag[k];
         sum += sq[k];
      end
      if (sum == 0) begin
         r = '0;
         r.zero = 1'b1;
      end else begin
         for (int k = 0; k < 3; k++) begin
            quo = ({48'd0, sq[k]} << (2 * FRAC_BITS)) / sum;
            root = floor_sqrt(quo[63:0]);
            u[k] = neg[k] ? -unit_type'(root) : unit_type'(root);
         end
         r.ux = u[0];
         r.uy = u[1];
         r.uz = u[2];
         r.zero = 1'b0;
      end
      r.last = last;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // sends one ray, bursts and random gaps between them
   task automatic send_ray(input comp_type x, input comp_type y, input comp_type z,
                           input logic last);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      req_chan.valid <= 1'b1;
      req_chan.comp_x <= x;
      req_chan.comp_y <= y;
      req_chan.comp_z <= z;
      req_chan.last_in <= last;
      unit_queue = {unit_queue, normalize_ray(x, y, z, last)};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      burst_left--;
      if (burst_left == 0) req_chan.valid <= 1'b0;
   endtask

   function automatic comp_type rand_comp();
      case ($urandom_range(0, 5))
         0: return comp_type'($urandom_range(0, 15)) - 8;
         1: return comp_type'($urandom_range(0, 255)) - 128;
         default: return comp_type'($urandom);
      endcase
   endfunction

   // receiver stalls follow a slowly changing pattern
   always @(posedge clock) begin
      if (stall_on) rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      else rsp_chan.ready <= 1'b1;
   end

   // check each response item against the oldest expectation
   always @(posedge clock) begin
      unit_vec_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (unit_queue.size() == 0) begin
            report_mismatch("unexpected item", 0, 0);
         end else begin
            want = unit_queue.pop_front();
            if (rsp_chan.unit_x !== want.ux)
               report_mismatch("unit_x", rsp_chan.unit_x, want.ux);
            if (rsp_chan.unit_y !== want.uy)
               report_mismatch("unit_y", rsp_chan.unit_y, want.uy);
            if (rsp_chan.unit_z !== want.uz)
               report_mismatch("unit_z", rsp_chan.unit_z, want.uz);
            if (rsp_chan.zero_vector !== want.zero)
               report_mismatch("zero_vector", rsp_chan.zero_vector, want.zero);
            if (rsp_chan.last_out !== want.last)
               report_mismatch("last_out", rsp_chan.last_out, want.last);
         end
      end
   end

   // extremes, axes, zero vector and most negative component
   task automatic test_directed();
      comp_type maxc;
      comp_type minc;
      maxc = comp_type'(8388607);
      minc = comp_type'(-8388608);
      send_ray(0, 0, 0, 1'b0);
      send_ray(0, 0, 0, 1'b1);
      send_ray(maxc, 0, 0, 1'b0);
      send_ray(0, -maxc, 0, 1'b1);
      send_ray(0, 0, 1, 1'b0);
      send_ray(-1, 0, 0, 1'b0);
      send_ray(minc, 0, 0, 1'b0);
      send_ray(minc, minc, minc, 1'b1);
      send_ray(maxc, maxc, maxc, 1'b0);
      send_ray(-maxc, -maxc, -maxc, 1'b0);
      send_ray(minc, maxc, 1, 1'b0);
      send_ray(-1, maxc, -1, 1'b0);
      send_ray(1, 1, 1, 1'b0);
      send_ray(-1, -1, 1, 1'b1);
      send_ray(3, -4, 0, 1'b0);
      send_ray(comp_type'(-24'h555555), comp_type'(24'h2aaaaa), 0, 1'b0);
      send_ray(comp_type'(24'h2aaaaa), -1, comp_type'(-24'h555555), 1'b0);
   endtask

   task automatic test_random();
      for (int i = 0; i < 600; i++) begin
         if (i % 150 == 0) stall_on = ~stall_on;
         send_ray(rand_comp(), rand_comp(), rand_comp(), $urandom_range(0, 1));
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.comp_x = '0;
      req_chan.comp_y = '0;
      req_chan.comp_z = '0;
      req_chan.last_in = 1'b0;
      rsp_chan.ready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      if (burst_left != 0) begin
         req_chan.valid <= 1'b0;
         burst_left = 0;
      end
      while (unit_queue.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 10) @(posedge clock);
      if (error_count == 0) $display("PASS direction_vector_normalize");
      else $display("FAIL direction_vector_normalize");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL direction_vector_normalize");
      $finish;
   end

endmodule
